// File: src/iwm_pkg.sv
// Package for the idle workload monitor: widths, codes, constants and shared types.
package iwm_pkg;

  localparam int unsigned WORD_W    = 32;
  localparam int unsigned TICKS_W   = 10;
  localparam int unsigned SHIFT_W   = 5;
  localparam int unsigned LOAD_W    = 10;
  localparam int unsigned STATUS_W  = 2;
  localparam int unsigned OPCODE_W  = 3;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = 10;
  localparam int unsigned STEP_W    = 5;

  localparam logic [WORD_W-1:0]  CAL_UNITS     = 32'd1000;
  localparam logic [WORD_W-1:0]  PERMILLE_FULL = 32'd1000;
  localparam logic [TICKS_W-1:0] CAL_WINDOW    = 10'd100;
  localparam logic [TICKS_W-1:0] WINDOW_MIN    = 10'd10;
  localparam logic [TICKS_W-1:0] WINDOW_MAX    = 10'd1000;
  localparam logic [TICKS_W-1:0] WINDOW_RESET  = 10'd100;
  localparam logic [SHIFT_W-1:0] SHIFT_RESET   = 5'd10;
  localparam logic [STEP_W-1:0]  LAST_STEP     = 5'd31;

  typedef enum logic [OPCODE_W-1:0] {
    OP_CAL_START  = 3'd0,
    OP_CAL_END    = 3'd1,
    OP_IDLE_UNIT  = 3'd2,
    OP_TICK       = 3'd3,
    OP_IDLE_START = 3'd4,
    OP_IDLE_END   = 3'd5,
    OP_READ       = 3'd6,
    OP_NONE       = 3'd7
  } opcode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WINDOW_TICKS = 2'd0,
    REG_SCALE_SHIFT  = 2'd1
  } reg_idx_e;

  localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_CLAMPED   = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_ZERO_SPAN = 2'd2;

  typedef enum logic {
    ARITH_MUL = 1'b0,
    ARITH_DIV = 1'b1
  } arith_op_e;

  typedef struct packed {
    logic              start;
    arith_op_e         op;
    logic [WORD_W-1:0] a;
    logic [WORD_W-1:0] b;
  } arith_req_t;

  typedef struct packed {
    logic              done;
    logic [WORD_W-1:0] result;
  } arith_rsp_t;

endpackage

// File: src/iwm_if.sv
// Channel interfaces of the idle workload monitor: event, result and register write.
interface iwm_evt_if
  import iwm_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [OPCODE_W-1:0] opcode;
  logic [WORD_W-1:0]   now_cycles;
  logic                read_request;

  modport source (output valid, output opcode, output now_cycles, output read_request,
                  input ready);
  modport sink   (input valid, input opcode, input now_cycles, input read_request,
                  output ready);
endinterface

interface iwm_res_if
  import iwm_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [LOAD_W-1:0]   load_permille;
  logic [STATUS_W-1:0] status;

  modport source (output valid, output load_permille, output status, input ready);
  modport sink   (input valid, input load_permille, input status, output ready);
endinterface

interface iwm_cfg_if
  import iwm_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_DAT_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// File: src/iwm_arith.sv
// Shared bit-serial unit: 32-bit wrapping multiply and unsigned divide, one bit a cycle.
module iwm_arith
  import iwm_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  arith_req_t req_i,
  output arith_rsp_t rsp_o
);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [STEP_W-1:0] step_q, step_d;
  arith_op_e         op_q, op_d;
  logic [WORD_W-1:0] a_q, a_d;
  logic [WORD_W-1:0] b_q, b_d;
  logic [WORD_W-1:0] acc_q, acc_d;
  logic [WORD_W-1:0] rem_q, rem_d;
  logic [WORD_W:0]   trial;
  logic [WORD_W:0]   diff;

  assign trial = {rem_q, a_q[WORD_W-1]};
  assign diff  = trial - {1'b0, b_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    step_d = step_q;
    op_d   = op_q;
    a_d    = a_q;
    b_d    = b_q;
    acc_d  = acc_q;
    rem_d  = rem_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      step_d = '0;
      op_d   = req_i.op;
      a_d    = req_i.a;
      b_d    = req_i.b;
      acc_d  = '0;
      rem_d  = '0;
    end else if (busy_q) begin
      step_d = step_q + 1'b1;
      if (step_q == LAST_STEP) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
      case (op_q)
        ARITH_MUL: begin
          // add the shifted multiplicand where the multiplier bit is set
          if (b_q[0]) begin
            acc_d = acc_q + a_q;
          end
          a_d = {a_q[WORD_W-2:0], 1'b0};
          b_d = {1'b0, b_q[WORD_W-1:1]};
        end
        ARITH_DIV: begin
          // restoring step: quotient bits shift into the dividend register
          if (!diff[WORD_W]) begin
            rem_d = diff[WORD_W-1:0];
            a_d   = {a_q[WORD_W-2:0], 1'b1};
          end else begin
            rem_d = trial[WORD_W-1:0];
            a_d   = {a_q[WORD_W-2:0], 1'b0};
          end
        end
        default: begin
          busy_d = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q  <= op_d;
    a_q   <= a_d;
    b_q   <= b_d;
    acc_q <= acc_d;
    rem_q <= rem_d;
  end

  assign rsp_o.done   = done_q;
  assign rsp_o.result = (op_q == ARITH_MUL) ? acc_q : a_q;

endmodule

// File: src/idle_workload_monitor.sv
// Top level of the idle workload monitor: event sequencer, window state and result register.
//
//   channel   dir  word                                    accepted when
//   in_chan   in   opcode, now_cycles, read_request        valid && ready
//   out_chan  out  load_permille, status                   valid && ready
//   cfg_chan  in   index (0 window_ticks, 1 scale_shift)   valid && ready
//
// Steps: calibration, idle unit, tick and idle start words are done at acceptance; idle end
// (with calibration done) runs issue, 32 multiply steps, handoff, 32 divide steps
// and writeback. A read runs the same steps and then loads the output register, or goes
// straight to that load when its scaled span is zero and the shared serial unit is skipped.
// Reset clears all window state to zero and the registers to 100 ticks, shift 10.
// in_chan.ready drops while a word is worked on; a reading waits only behind an untaken one.
module idle_workload_monitor
  import iwm_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  iwm_evt_if.sink  in_chan,
  iwm_res_if.source out_chan,
  iwm_cfg_if.sink  cfg_chan
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_MUL  = 4'b0010,
    ST_DIV  = 4'b0100,
    ST_WB   = 4'b1000
  } state_e;

  state_e state_q, state_d;

  // registers
  logic [TICKS_W-1:0] window_ticks_q, window_ticks_d;
  logic [SHIFT_W-1:0] scale_shift_q, scale_shift_d;

  // window state
  logic [WORD_W-1:0]  idle_units_q, idle_units_d;
  logic [WORD_W-1:0]  win_start_units_q, win_start_units_d;
  logic [WORD_W-1:0]  win_end_units_q, win_end_units_d;
  logic [WORD_W-1:0]  win_start_time_q, win_start_time_d;
  logic [WORD_W-1:0]  win_end_time_q, win_end_time_d;
  logic [WORD_W-1:0]  cal_units_q, cal_units_d;
  logic [WORD_W-1:0]  cal_cycles_q, cal_cycles_d;
  logic [WORD_W-1:0]  ref_time_q, ref_time_d;
  logic [TICKS_W-1:0] ticks_left_q, ticks_left_d;
  logic [WORD_W-1:0]  idle_begin_q, idle_begin_d;

  // job context while the shared unit runs
  logic               job_read_q, job_read_d;
  logic [WORD_W-1:0]  divisor_q, divisor_d;

  // pending and presented result
  logic [LOAD_W-1:0]   pend_load_q, pend_load_d;
  logic [STATUS_W-1:0] pend_status_q, pend_status_d;
  logic                out_valid_q, out_valid_d;
  logic [LOAD_W-1:0]   out_load_q, out_load_d;
  logic [STATUS_W-1:0] out_status_q, out_status_d;

  arith_req_t arith_req;
  arith_rsp_t arith_rsp;

  logic               evt_fire;
  logic               is_read;
  opcode_e            op;
  logic [WORD_W-1:0]  now;
  logic [WORD_W-1:0]  span;
  logic [WORD_W-1:0]  scaled_span;
  logic [TICKS_W-1:0] ticks_dec;
  logic [TICKS_W-1:0] cfg_window;

  iwm_arith u_arith (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (arith_req),
    .rsp_o  (arith_rsp)
  );

  assign in_chan.ready  = (state_q == ST_IDLE);
  assign cfg_chan.ready = 1'b1;
  assign evt_fire       = in_chan.valid && in_chan.ready;
  assign op             = opcode_e'(in_chan.opcode);
  assign is_read        = in_chan.read_request || (op == OP_READ);
  assign now            = in_chan.now_cycles;
  // span since window start; serves both the read and the calibration end
  assign span           = now - win_start_time_q;
  assign scaled_span    = span >> scale_shift_q;
  assign ticks_dec      = ticks_left_q - 1'b1;

  // clamp window writes into the legal range
  always_comb begin
    cfg_window = cfg_chan.data[TICKS_W-1:0];
    if (cfg_window < WINDOW_MIN) begin
      cfg_window = WINDOW_MIN;
    end else if (cfg_window > WINDOW_MAX) begin
      cfg_window = WINDOW_MAX;
    end
  end

  always_comb begin
    state_d           = state_q;
    window_ticks_d    = window_ticks_q;
    scale_shift_d     = scale_shift_q;
    idle_units_d      = idle_units_q;
    win_start_units_d = win_start_units_q;
    win_end_units_d   = win_end_units_q;
    win_start_time_d  = win_start_time_q;
    win_end_time_d    = win_end_time_q;
    cal_units_d       = cal_units_q;
    cal_cycles_d      = cal_cycles_q;
    ref_time_d        = ref_time_q;
    ticks_left_d      = ticks_left_q;
    idle_begin_d      = idle_begin_q;
    job_read_d        = job_read_q;
    divisor_d         = divisor_q;
    pend_load_d       = pend_load_q;
    pend_status_d     = pend_status_q;
    out_valid_d       = out_valid_q;
    out_load_d        = out_load_q;
    out_status_d      = out_status_q;
    arith_req.start   = 1'b0;
    arith_req.op      = ARITH_MUL;
    arith_req.a       = '0;
    arith_req.b       = '0;

    // drop the presented word once taken
    if (out_valid_q && out_chan.ready) begin
      out_valid_d = 1'b0;
    end

    if (cfg_chan.valid) begin
      case (reg_idx_e'(cfg_chan.index))
        REG_WINDOW_TICKS: window_ticks_d = cfg_window;
        REG_SCALE_SHIFT:  scale_shift_d  = cfg_chan.data[SHIFT_W-1:0];
        default: ;
      endcase
    end

    case (state_q)
      ST_IDLE: begin
        if (evt_fire) begin
          if (is_read) begin
            if (scaled_span == '0) begin
              pend_load_d   = '0;
              pend_status_d = STATUS_ZERO_SPAN;
              state_d       = ST_WB;
            end else begin
              // k = (idle_units - start units) * reference time, then k / t
              job_read_d      = 1'b1;
              divisor_d       = scaled_span;
              arith_req.start = 1'b1;
              arith_req.op    = ARITH_MUL;
              arith_req.a     = idle_units_q - win_start_units_q;
              arith_req.b     = ref_time_q;
              state_d         = ST_MUL;
            end
          end else begin
            case (op)
              OP_CAL_START: begin
                idle_units_d      = '0;
                win_start_units_d = '0;
                win_end_units_d   = CAL_UNITS;
                win_start_time_d  = now;
              end
              OP_CAL_END: begin
                win_end_time_d = now;
                cal_cycles_d   = span;
                idle_units_d   = CAL_UNITS;
                cal_units_d    = CAL_UNITS;
                ref_time_d     = scaled_span;
                window_ticks_d = CAL_WINDOW;
                ticks_left_d   = CAL_WINDOW;
              end
              OP_IDLE_UNIT: begin
                idle_units_d = idle_units_q + 1'b1;
              end
              OP_TICK: begin
                ticks_left_d = ticks_dec;
                // window closes: snapshot counts and times, reload the count
                if (ticks_dec == '0) begin
                  win_start_time_d  = win_end_time_q;
                  win_end_time_d    = now;
                  win_start_units_d = win_end_units_q;
                  win_end_units_d   = idle_units_q - 1'b1;
                  ticks_left_d      = window_ticks_q;
                end
              end
              OP_IDLE_START: begin
                idle_begin_d = now;
              end
              OP_IDLE_END: begin
                // credit units in proportion to idle cycles; skip before calibration
                if (cal_cycles_q != '0) begin
                  job_read_d      = 1'b0;
                  divisor_d       = cal_cycles_q;
                  arith_req.start = 1'b1;
                  arith_req.op    = ARITH_MUL;
                  arith_req.a     = cal_units_q;
                  arith_req.b     = now - idle_begin_q;
                  state_d         = ST_MUL;
                end
              end
              default: ;
            endcase
          end
        end
      end
      ST_MUL: begin
        if (arith_rsp.done) begin
          arith_req.start = 1'b1;
          arith_req.op    = ARITH_DIV;
          arith_req.a     = arith_rsp.result;
          arith_req.b     = divisor_q;
          state_d         = ST_DIV;
        end
      end
      ST_DIV: begin
        if (arith_rsp.done) begin
          if (job_read_q) begin
            if (arith_rsp.result > PERMILLE_FULL) begin
              pend_load_d   = '0;
              pend_status_d = STATUS_CLAMPED;
            end else begin
              pend_load_d   = PERMILLE_FULL[LOAD_W-1:0] - arith_rsp.result[LOAD_W-1:0];
              pend_status_d = STATUS_OK;
            end
            state_d = ST_WB;
          end else begin
            idle_units_d = idle_units_q + arith_rsp.result;
            state_d      = ST_IDLE;
          end
        end
      end
      ST_WB: begin
        // hold until the output register is free
        if (!out_valid_q || out_chan.ready) begin
          out_valid_d  = 1'b1;
          out_load_d   = pend_load_q;
          out_status_d = pend_status_q;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q           <= ST_IDLE;
      window_ticks_q    <= WINDOW_RESET;
      scale_shift_q     <= SHIFT_RESET;
      idle_units_q      <= '0;
      win_start_units_q <= '0;
      win_end_units_q   <= '0;
      win_start_time_q  <= '0;
      win_end_time_q    <= '0;
      cal_units_q       <= '0;
      cal_cycles_q      <= '0;
      ref_time_q        <= '0;
      ticks_left_q      <= '0;
      idle_begin_q      <= '0;
      out_valid_q       <= 1'b0;
    end else begin
      state_q           <= state_d;
      window_ticks_q    <= window_ticks_d;
      scale_shift_q     <= scale_shift_d;
      idle_units_q      <= idle_units_d;
      win_start_units_q <= win_start_units_d;
      win_end_units_q   <= win_end_units_d;
      win_start_time_q  <= win_start_time_d;
      win_end_time_q    <= win_end_time_d;
      cal_units_q       <= cal_units_d;
      cal_cycles_q      <= cal_cycles_d;
      ref_time_q        <= ref_time_d;
      ticks_left_q      <= ticks_left_d;
      idle_begin_q      <= idle_begin_d;
      out_valid_q       <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    job_read_q    <= job_read_d;
    divisor_q     <= divisor_d;
    pend_load_q   <= pend_load_d;
    pend_status_q <= pend_status_d;
    out_load_q    <= out_load_d;
    out_status_q  <= out_status_d;
  end

  assign out_chan.valid         = out_valid_q;
  assign out_chan.load_permille = out_load_q;
  assign out_chan.status        = out_status_q;

endmodule
